// ----- rtl/core/tplrr_pkg.sv -----
// Shared types and constants for the two-level priority / round-robin scheduler.
// Used by every module in rtl/core; depends on nothing else.
package tplrr_pkg;

  // Sizing of the task stores and the burst counter.
  localparam int unsigned MaxTasks  = 16;
  localparam int unsigned BurstBits = 16;
  localparam int unsigned IdxW      = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW      = IdxW + 1;

  // Width of the time quantum register and its reset value.
  localparam int unsigned QuantW    = 8;
  localparam logic [QuantW-1:0] QuantumReset = QuantW'(2);

  // One scheduled task: identifier, priority and remaining burst.
  typedef struct packed {
    logic [7:0]           id;
    logic [7:0]           prio;
    logic [BurstBits-1:0] rem;
  } task_t;

  // Request operation codes.
  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  // Origin of the task that currently owns the CPU.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_L1   = 2'd1,
    SRC_RR   = 2'd2
  } src_e;

  // Outcome of one pass of the scan unit over the level-one store.
  typedef struct packed {
    logic            done;
    logic            found;
    logic [IdxW-1:0] idx;
    task_t           best;
  } scan_res_t;

  // Occupancy of the level-one store.
  typedef struct packed {
    logic            full;
    logic [IdxW-1:0] free_idx;
  } store_stat_t;

  // Occupancy of the round-robin queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/core/tplrr_l1_store.sv -----
// Level-one priority store: task memory with one write and one registered read
// port, per-slot valid flags and a first-free-slot encoder. Depends on tplrr_pkg.
module tplrr_l1_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  tplrr_pkg::task_t             wr_data_i,
  input  logic                         clr_en_i,
  input  logic [tplrr_pkg::IdxW-1:0]   clr_idx_i,
  input  logic [tplrr_pkg::IdxW-1:0]   rd_addr_i,
  output tplrr_pkg::task_t             rd_data_o,
  output logic [tplrr_pkg::MaxTasks-1:0] valid_o,
  output tplrr_pkg::store_stat_t       stat_o
);

  tplrr_pkg::task_t                   mem_q [tplrr_pkg::MaxTasks];
  tplrr_pkg::task_t                   rd_q;
  logic [tplrr_pkg::MaxTasks-1:0]     valid_q;
  logic [tplrr_pkg::MaxTasks-1:0]     valid_d;
  logic [tplrr_pkg::IdxW-1:0]         free_idx;

  // Lowest slot that holds no task.
  always_comb begin
    free_idx = '0;
    for (int i = tplrr_pkg::MaxTasks - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = tplrr_pkg::IdxW'(i);
      end
    end
  end

  // Valid flags: set on a write, cleared when a task is dispatched.
  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[free_idx] = 1'b1;
    end
    if (clr_en_i) begin
      valid_d[clr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Task memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[free_idx] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o       = rd_q;
  assign valid_o         = valid_q;
  assign stat_o.full     = &valid_q;
  assign stat_o.free_idx = free_idx;

endmodule

// ----- rtl/core/tplrr_scan_unit.sv -----
// Scan unit: walks the level-one store one slot per cycle through a shared
// compare unit and keeps the best task seen. Depends on tplrr_pkg.
module tplrr_scan_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tplrr_pkg::MaxTasks-1:0] valid_i,
  input  tplrr_pkg::task_t               rd_data_i,
  output logic [tplrr_pkg::IdxW-1:0]     rd_addr_o,
  output tplrr_pkg::scan_res_t           res_o
);

  logic                         active_q;
  logic [tplrr_pkg::CntW-1:0]   issue_q;
  logic                         cmp_vld_q;
  logic [tplrr_pkg::IdxW-1:0]   cmp_idx_q;
  logic                         found_q;
  logic [tplrr_pkg::IdxW-1:0]   best_idx_q;
  tplrr_pkg::task_t             best_q;
  logic                         issuing;
  logic                         better;
  logic                         done;

  assign issuing   = active_q && (issue_q != tplrr_pkg::CntW'(tplrr_pkg::MaxTasks));
  assign done      = active_q && !issuing && !cmp_vld_q;
  assign rd_addr_o = issue_q[tplrr_pkg::IdxW-1:0];

  // Shared compare: lower priority wins, then lower id; ties keep the earlier slot.
  assign better = cmp_vld_q && valid_i[cmp_idx_q] &&
                  (!found_q || (rd_data_i.prio < best_q.prio) ||
                   ((rd_data_i.prio == best_q.prio) && (rd_data_i.id < best_q.id)));

  // Slot counter and compare pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      if (start_i) begin
        active_q  <= 1'b1;
        issue_q   <= '0;
        cmp_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        cmp_vld_q <= issuing;
        if (issuing) begin
          issue_q <= issue_q + tplrr_pkg::CntW'(1);
        end
        if (better) begin
          found_q <= 1'b1;
        end
        if (done) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // Best-candidate payload.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= issue_q[tplrr_pkg::IdxW-1:0];
    if (better) begin
      best_q     <= rd_data_i;
      best_idx_q <= cmp_idx_q;
    end
  end

  assign res_o.done  = done;
  assign res_o.found = found_q;
  assign res_o.idx   = best_idx_q;
  assign res_o.best  = best_q;

endmodule

// ----- rtl/core/tplrr_rr_fifo.sv -----
// Round-robin queue: circular task memory with head, tail and count, and a
// registered read of the head entry. Depends on tplrr_pkg.
module tplrr_rr_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tplrr_pkg::task_t       push_data_i,
  input  logic                   pop_i,
  output tplrr_pkg::task_t       head_data_o,
  output tplrr_pkg::fifo_stat_t  stat_o
);

  tplrr_pkg::task_t             mem_q [tplrr_pkg::MaxTasks];
  tplrr_pkg::task_t             head_q_data;
  logic [tplrr_pkg::IdxW-1:0]   head_q;
  logic [tplrr_pkg::IdxW-1:0]   tail_q;
  logic [tplrr_pkg::CntW-1:0]   count_q;
  logic                         full;
  logic                         do_push;
  logic                         do_pop;

  localparam logic [tplrr_pkg::IdxW-1:0] LastIdx = tplrr_pkg::IdxW'(tplrr_pkg::MaxTasks - 1);

  assign full    = (count_q == tplrr_pkg::CntW'(tplrr_pkg::MaxTasks));
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && (count_q != '0);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        tail_q <= (tail_q == LastIdx) ? '0 : tail_q + tplrr_pkg::IdxW'(1);
      end
      if (do_pop) begin
        head_q <= (head_q == LastIdx) ? '0 : head_q + tplrr_pkg::IdxW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + tplrr_pkg::CntW'(1);
        2'b01:   count_q <= count_q - tplrr_pkg::CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Queue memory; the head entry is read every cycle.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= push_data_i;
    end
    head_q_data <= mem_q[head_q];
  end

  assign head_data_o  = head_q_data;
  assign stat_o.full  = full;
  assign stat_o.empty = (count_q == '0);

endmodule

// ----- rtl/core/two_level_priority_rr_scheduler_core.sv -----
// Top level of the two-level scheduler: request sequencer, CPU state and result
// register. Depends on tplrr_pkg, tplrr_l1_store, tplrr_scan_unit, tplrr_rr_fifo.
//
// Channel   Direction  Handshake            Payload
// request   in         in_valid_i/in_stall_o  operation, task_id, task_priority, burst_length
// result    out        out_valid_o/out_stall_i busy_res, running_id, from_round_robin,
//                                            completed, overflow
// config    in         cfg_valid_i/cfg_ready_o cfg_data_i (time quantum)
//
// An arrival request is accepted in idle, then written to the store in the arrive state.
// A tick request is accepted, then walks the level-one store in the scan state (one store
// slot per cycle through the single memory read port, plus the read and compare
// pipeline), then passes through the decide and execute states.
// Only one request is in work at a time; in_stall_o is high until it is done.
// A tick waits in execute while a previous result is still stalled at the output.
// Reset is asynchronous and active low; it empties both stores and idles the CPU.
module two_level_priority_rr_scheduler_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [7:0]                task_id_i,
  input  logic [7:0]                task_priority_i,
  input  logic [15:0]               burst_length_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      busy_res_o,
  output logic [7:0]                running_id_o,
  output logic                      from_round_robin_o,
  output logic                      completed_o,
  output logic                      overflow_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tplrr_pkg::QuantW-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ARRIVE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_EXEC   = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [tplrr_pkg::QuantW-1:0]    quantum_q;
  logic [7:0]                      req_id_q;
  logic [7:0]                      req_prio_q;
  logic [15:0]                     req_burst_q;
  tplrr_pkg::task_t                cur_q, cur_d;
  logic                            busy_q, busy_d;
  tplrr_pkg::src_e                 src_q, src_d;
  logic [tplrr_pkg::QuantW-1:0]    ql_q, ql_d;
  logic                            ovf_q, ovf_d;
  logic                            out_valid_q;
  logic                            out_busy_q;
  logic [7:0]                      out_id_q;
  logic                            out_rr_q;
  logic                            out_done_q;
  logic                            out_ovf_q;

  logic                            accept;
  logic                            exec_go;
  logic [tplrr_pkg::QuantW-1:0]    load_quantum;
  logic [tplrr_pkg::BurstBits-1:0] req_burst;
  logic [tplrr_pkg::BurstBits-1:0] rem_dec;
  logic [tplrr_pkg::QuantW-1:0]    ql_dec;
  logic                            run_done;
  logic                            run_expire;
  logic                            take_l1;
  logic                            do_pop;
  logic                            st_wr_en;
  tplrr_pkg::task_t                st_wr_data;
  logic [tplrr_pkg::IdxW-1:0]      st_rd_addr;
  tplrr_pkg::task_t                st_rd_data;
  logic [tplrr_pkg::MaxTasks-1:0]  st_valid;
  tplrr_pkg::store_stat_t          st_stat;
  tplrr_pkg::scan_res_t            scan_res;
  logic                            ff_push;
  tplrr_pkg::task_t                ff_push_data;
  tplrr_pkg::task_t                ff_head;
  tplrr_pkg::fifo_stat_t           ff_stat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign exec_go     = !out_valid_q || !out_stall_i;

  // A zero quantum behaves as one.
  assign load_quantum = (quantum_q == '0) ? tplrr_pkg::QuantW'(1) : quantum_q;
  assign req_burst    = tplrr_pkg::BurstBits'(req_burst_q);

  // Run step of the current task.
  assign rem_dec    = cur_q.rem - tplrr_pkg::BurstBits'(1);
  assign ql_dec     = ql_q - tplrr_pkg::QuantW'(1);
  assign run_done   = (rem_dec == '0);
  assign run_expire = !run_done && (ql_dec == '0);

  // Dispatch decision from the scan result.
  assign take_l1 = (state_q == ST_DECIDE) && scan_res.found &&
                   (!busy_q || (src_q != tplrr_pkg::SRC_L1) ||
                    (scan_res.best.prio < cur_q.prio));
  assign do_pop  = (state_q == ST_DECIDE) && !busy_q && !scan_res.found && !ff_stat.empty;

  // Store write for an arrival with a nonzero burst while the store has a free slot.
  assign st_wr_en        = (state_q == ST_ARRIVE) && (req_burst != '0) && !st_stat.full;
  assign st_wr_data.id   = req_id_q;
  assign st_wr_data.prio = req_prio_q;
  assign st_wr_data.rem  = req_burst;

  // Queue pushes: a preempted runner, or a runner whose quantum ran out.
  always_comb begin
    ff_push      = 1'b0;
    ff_push_data = cur_q;
    if ((state_q == ST_DECIDE) && take_l1 && busy_q) begin
      ff_push = 1'b1;
    end else if ((state_q == ST_EXEC) && exec_go && busy_q && run_expire) begin
      ff_push          = 1'b1;
      ff_push_data.rem = rem_dec;
    end
  end

  // Sequencer and CPU state update.
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    busy_d  = busy_q;
    src_d   = src_q;
    ql_d    = ql_q;
    ovf_d   = ovf_q;
    if (ff_push && ff_stat.full) begin
      ovf_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (tplrr_pkg::op_e'(operation_i) == tplrr_pkg::OP_TICK) ? ST_SCAN
                                                                          : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        if ((req_burst != '0) && st_stat.full) begin
          ovf_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (take_l1) begin
          cur_d  = scan_res.best;
          busy_d = 1'b1;
          src_d  = tplrr_pkg::SRC_L1;
          ql_d   = load_quantum;
        end else if (do_pop) begin
          cur_d  = ff_head;
          busy_d = 1'b1;
          src_d  = tplrr_pkg::SRC_RR;
          ql_d   = load_quantum;
        end
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          if (busy_q) begin
            cur_d.rem = rem_dec;
            ql_d      = ql_dec;
            if (run_done || run_expire) begin
              cur_d  = '0;
              busy_d = 1'b0;
              src_d  = tplrr_pkg::SRC_NONE;
            end
            if (run_done) begin
              ql_d = load_quantum;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and CPU registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      quantum_q <= tplrr_pkg::QuantumReset;
      cur_q     <= '0;
      busy_q    <= 1'b0;
      src_q     <= tplrr_pkg::SRC_NONE;
      ql_q      <= tplrr_pkg::QuantumReset;
      ovf_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      busy_q  <= busy_d;
      src_q   <= src_d;
      ql_q    <= ql_d;
      ovf_q   <= ovf_d;
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  // Captured request payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_id_q    <= task_id_i;
      req_prio_q  <= task_priority_i;
      req_burst_q <= burst_length_i;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EXEC) && exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EXEC) && exec_go) begin
      out_busy_q <= busy_q;
      out_id_q   <= busy_q ? cur_q.id : 8'd0;
      out_rr_q   <= busy_q && (src_q == tplrr_pkg::SRC_RR);
      out_done_q <= busy_q && run_done;
      out_ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign busy_res_o         = out_busy_q;
  assign running_id_o       = out_id_q;
  assign from_round_robin_o = out_rr_q;
  assign completed_o        = out_done_q;
  assign overflow_o         = out_ovf_q;

  tplrr_l1_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (st_wr_en),
    .wr_data_i (st_wr_data),
    .clr_en_i  (take_l1),
    .clr_idx_i (scan_res.idx),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data),
    .valid_o   (st_valid),
    .stat_o    (st_stat)
  );

  tplrr_scan_unit u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && (tplrr_pkg::op_e'(operation_i) == tplrr_pkg::OP_TICK)),
    .valid_i   (st_valid),
    .rd_data_i (st_rd_data),
    .rd_addr_o (st_rd_addr),
    .res_o     (scan_res)
  );

  tplrr_rr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ff_push),
    .push_data_i (ff_push_data),
    .pop_i       (do_pop),
    .head_data_o (ff_head),
    .stat_o      (ff_stat)
  );

endmodule
